>>> rtl/bspq_pkg.sv
// Shared types and constants for the bounded sorted priority queue.
package bspq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PRIO_W      = 32;
    localparam int HANDLE_W    = 16;
    localparam int FILL_W      = 4;

    // Item kinds carried on s_tuser
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef struct packed {
        logic                valid;
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // Operation broadcast to every cell in the same cycle
    typedef struct packed {
        logic                enq;
        logic                deq;
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
    } op_t;

endpackage

>>> rtl/bounded_sorted_priority_queue_unit.sv
// Bounded sorted priority queue: QUEUE_DEPTH slots, highest priority at the head,
// equal priorities kept in arrival order; a full queue drops its tail on enqueue.
// For each item, the new priority is compared in every slot at once, and
// each slot picks keep, new item or neighbor, so the 32-bit compare plus a 4-way
// select per slot is the critical path. An item is accepted whenever the result
// register is empty or is taken in the same cycle, giving one item per cycle.
// No clearing pass after reset.
module bounded_sorted_priority_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // priority_req[31:0], conn_handle[47:32]
    input  logic        s_tuser,   // mode: 0 enqueue, 1 dequeue
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // ok[0], head_handle[16:1], head_priority[48:17],
                                   // evicted[49], fill_count[53:50], zero[55:54]
);

    localparam int N = bspq_pkg::QUEUE_DEPTH;

    bspq_pkg::entry_t cell_entry [N];
    logic             cell_ge    [N];
    bspq_pkg::op_t    op;
    bspq_pkg::entry_t empty_entry;

    logic                        s_acc;
    logic [bspq_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        m_valid_reg;
    logic [55:0]                 m_data_reg, m_data_next;
    logic                        full;
    logic                        evict;
    logic                        deq_ok;
    logic [bspq_pkg::FILL_W-1:0] fill;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign op.enq    = s_acc && (s_tuser == bspq_pkg::MODE_ENQ);
    assign op.deq    = s_acc && (s_tuser == bspq_pkg::MODE_DEQ);
    assign op.prio   = s_tdata[31:0];
    assign op.handle = s_tdata[47:32];

    assign empty_entry = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            bspq_pkg::entry_t left_e;
            bspq_pkg::entry_t right_e;
            logic             left_g;
            if (g == 0) begin : g_head
                assign left_e = empty_entry;
                assign left_g = 1'b1;
            end else begin : g_mid
                assign left_e = cell_entry[g-1];
                assign left_g = cell_ge[g-1];
            end
            if (g == N - 1) begin : g_last
                assign right_e = empty_entry;
            end else begin : g_nlast
                assign right_e = cell_entry[g+1];
            end
            bspq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .op          (op),
                .is_tail     (g == N - 1),
                .left_entry  (left_e),
                .left_ge     (left_g),
                .right_entry (right_e),
                .own_entry   (cell_entry[g]),
                .own_ge      (cell_ge[g])
            );
        end
    endgenerate

    assign full   = (cnt_reg == bspq_pkg::CNT_W'(N));
    assign evict  = op.enq && full;
    assign deq_ok = cell_entry[0].valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (op.enq && !full) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (op.deq && deq_ok) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    assign fill = bspq_pkg::FILL_W'(cnt_next);

    always_comb begin
        m_data_next        = '0;
        m_data_next[53:50] = fill;
        m_data_next[49]    = evict;
        if (op.enq) begin
            m_data_next[0] = 1'b1;
        end else if (deq_ok) begin
            m_data_next[0]     = 1'b1;
            m_data_next[16:1]  = cell_entry[0].handle;
            m_data_next[48:17] = cell_entry[0].prio;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (s_acc) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            m_data_reg <= m_data_next;
        end
    end

    logic [N-1:0] valid_vec;
    always_comb begin
        for (int i = 0; i < N; i++) begin
            valid_vec[i] = cell_entry[i].valid;
        end
    end

    // Occupied slots always match the entry count
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == 32'(cnt_reg))
        else $error("slot occupancy differs from entry count");

    // Head never ranks below the second slot
    a_head_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_entry[1].valid |-> (cell_entry[0].prio >= cell_entry[1].prio))
        else $error("queue order broken at head");

    // Enqueue always reports success on the next result
    a_enq_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        op.enq |=> (m_tvalid && m_tdata[0]))
        else $error("enqueue did not report success");

    // Eviction only from a full queue
    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (!m_tdata[49] || $past(full)))
        else $error("eviction reported on a queue that was not full");

endmodule

>>> rtl/bspq_cell.sv
// One slot of the sorted shift-register queue.
module bspq_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  bspq_pkg::op_t    op,
    input  logic             is_tail,   // tie high on the last slot only
    input  bspq_pkg::entry_t left_entry,
    input  logic             left_ge,   // left slot stays put on insert
    input  bspq_pkg::entry_t right_entry,
    output bspq_pkg::entry_t own_entry,
    output logic             own_ge
);

    logic                          valid_reg, valid_next;
    logic [bspq_pkg::PRIO_W-1:0]   prio_reg, prio_next;
    logic [bspq_pkg::HANDLE_W-1:0] handle_reg, handle_next;

    // The tail slot always yields to a new item: when full its old content is dropped.
    assign own_ge = valid_reg && (prio_reg >= op.prio) && !is_tail;

    assign own_entry.valid  = valid_reg;
    assign own_entry.prio   = prio_reg;
    assign own_entry.handle = handle_reg;

    always_comb begin
        valid_next  = valid_reg;
        prio_next   = prio_reg;
        handle_next = handle_reg;
        if (op.enq && !own_ge) begin
            if (left_ge) begin
                valid_next  = 1'b1;
                prio_next   = op.prio;
                handle_next = op.handle;
            end else begin
                valid_next  = left_entry.valid;
                prio_next   = left_entry.prio;
                handle_next = left_entry.handle;
            end
        end else if (op.deq) begin
            valid_next  = right_entry.valid;
            prio_next   = right_entry.prio;
            handle_next = right_entry.handle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg   <= prio_next;
        handle_reg <= handle_next;
    end

endmodule
